>>> hw/rtl/m2ts_pkg.sv
// m2ts_pkg: shared types and constants for the millisecond timestamp text block
// no dependencies; used by every module under hw/rtl

package m2ts_pkg;

  // subtitle format register codes
  localparam logic FMT_SRT = 1'b0;
  localparam logic FMT_ASS = 1'b1;

  // ascii characters
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_COLON = 7'h3A;
  localparam logic [6:0] CH_COMMA = 7'h2C;
  localparam logic [6:0] CH_DOT   = 7'h2E;

  // reciprocal multipliers: x / d == (x * M) >> K for the stated input width
  localparam logic [28:0] RCP_SEC  = 29'd274877907;  // 32-bit x / 1000, K = 38
  localparam logic [23:0] RCP_MIN  = 24'd8947849;    // 23-bit x / 60,   K = 29
  localparam logic [17:0] RCP_HOUR = 18'd139811;     // 17-bit x / 60,   K = 23
  localparam logic [11:0] RCP_H100 = 12'd2622;       // 11-bit x / 100,  K = 18
  localparam logic [7:0]  RCP_D10  = 8'd205;         // 7-bit x / 10,    K = 11
  localparam logic [10:0] RCP_F100 = 11'd1311;       // 10-bit x / 100,  K = 17
  localparam logic [10:0] RCP_F10  = 11'd1639;       // 10-bit x / 10,   K = 14

  // time split into fields
  typedef struct packed {
    logic [6:0] hour;    // hours modulo 100
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] milli;
  } hmsf_t;

  // decimal digits of one timestamp
  typedef struct packed {
    logic [3:0] h1;
    logic [3:0] h0;
    logic [3:0] m1;
    logic [3:0] m0;
    logic [3:0] s1;
    logic [3:0] s0;
    logic [3:0] f2;
    logic [3:0] f1;
    logic [3:0] f0;
  } digits_t;

endpackage

>>> hw/rtl/m2ts_divide.sv
// m2ts_divide: six-stage pipeline that splits a millisecond count into h/m/s/ms
// depends on m2ts_pkg (reciprocal constants, hmsf_t)

module m2ts_divide (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       millis,
  output logic              out_valid,
  input  logic              out_ready,
  output m2ts_pkg::hmsf_t   out_time
);

  // stage valid bits
  logic v1, v2, v3, v4, v5, v6;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  // stage payload
  logic [31:0] t1;
  logic [22:0] sec2;
  logic [9:0]  tlo2;
  logic [16:0] min3;
  logic [5:0]  seclo3;
  logic [9:0]  f3;
  logic [10:0] hr4;
  logic [5:0]  minlo4;
  logic [5:0]  s4;
  logic [9:0]  f4;
  logic [3:0]  hq5;
  logic [6:0]  hrlo5;
  logic [5:0]  m5;
  logic [5:0]  s5;
  logic [9:0]  f5;
  m2ts_pkg::hmsf_t time6;

  // products
  logic [60:0] p_sec;
  logic [46:0] p_min;
  logic [9:0]  p_ms;
  logic [34:0] p_hour;
  logic [5:0]  p_s60;
  logic [22:0] p_h100;
  logic [5:0]  p_m60;
  logic [6:0]  p_hq;

  // a stage loads when it is empty or its contents move on
  assign rdy6 = !v6 || out_ready;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v6;
  assign out_time  = time6;

  // arithmetic between stages
  assign p_sec  = 61'(t1) * 61'(m2ts_pkg::RCP_SEC);
  assign p_min  = 47'(sec2) * 47'(m2ts_pkg::RCP_MIN);
  assign p_ms   = 10'(sec2[9:0] * 10'd1000);
  assign p_hour = 35'(min3) * 35'(m2ts_pkg::RCP_HOUR);
  assign p_s60  = 6'(min3[5:0] * 6'd60);
  assign p_h100 = 23'(hr4) * 23'(m2ts_pkg::RCP_H100);
  assign p_m60  = 6'(hr4[5:0] * 6'd60);
  assign p_hq   = 7'(hq5 * 7'd100);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    // capture input
    if (rdy1) t1 <= millis;
    // total seconds
    if (rdy2) begin
      sec2 <= p_sec[60:38];
      tlo2 <= t1[9:0];
    end
    // total minutes and milliseconds
    if (rdy3) begin
      min3   <= p_min[45:29];
      seclo3 <= sec2[5:0];
      f3     <= tlo2 - p_ms;
    end
    // total hours and seconds
    if (rdy4) begin
      hr4    <= p_hour[33:23];
      minlo4 <= min3[5:0];
      s4     <= seclo3 - p_s60;
      f4     <= f3;
    end
    // hundreds of hours and minutes
    if (rdy5) begin
      hq5   <= p_h100[21:18];
      hrlo5 <= hr4[6:0];
      m5    <= minlo4 - p_m60;
      s5    <= s4;
      f5    <= f4;
    end
    // hours modulo 100
    if (rdy6) begin
      time6.hour   <= hrlo5 - p_hq;
      time6.minute <= m5;
      time6.second <= s5;
      time6.milli  <= f5;
    end
  end

endmodule

>>> hw/rtl/m2ts_digits.sv
// m2ts_digits: one pipeline stage that turns h/m/s/ms fields into decimal digits
// depends on m2ts_pkg (hmsf_t, digits_t, reciprocal constants)

module m2ts_digits (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  m2ts_pkg::hmsf_t   in_time,
  output logic              out_valid,
  input  logic              out_ready,
  output m2ts_pkg::digits_t out_digits
);

  logic              v;
  m2ts_pkg::digits_t dig;
  m2ts_pkg::digits_t dig_next;

  logic [3:0]  h_t, m_t, s_t;
  logic [20:0] p_f100;
  logic [20:0] p_f10;
  logic [3:0]  f_hund;
  logic [6:0]  f_tens;

  // tens digit of a value below 100
  function automatic logic [3:0] tens_of(input logic [6:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'(m2ts_pkg::RCP_D10);
    return p[14:11];
  endfunction

  assign in_ready   = !v || out_ready;
  assign out_valid  = v;
  assign out_digits = dig;

  // digit split
  assign h_t    = tens_of(in_time.hour);
  assign m_t    = tens_of(7'(in_time.minute));
  assign s_t    = tens_of(7'(in_time.second));
  assign p_f100 = 21'(in_time.milli) * 21'(m2ts_pkg::RCP_F100);
  assign p_f10  = 21'(in_time.milli) * 21'(m2ts_pkg::RCP_F10);
  assign f_hund = p_f100[20:17];
  assign f_tens = p_f10[20:14];

  always_comb begin
    dig_next.h1 = h_t;
    dig_next.h0 = 4'(in_time.hour - 7'(h_t * 7'd10));
    dig_next.m1 = m_t;
    dig_next.m0 = 4'(in_time.minute - 6'(m_t * 6'd10));
    dig_next.s1 = s_t;
    dig_next.s0 = 4'(in_time.second - 6'(s_t * 6'd10));
    dig_next.f2 = f_hund;
    dig_next.f1 = 4'(f_tens - 7'(f_hund * 7'd10));
    dig_next.f0 = 4'(in_time.milli - 10'(f_tens * 10'd10));
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) dig <= dig_next;
  end

endmodule

>>> hw/rtl/m2ts_serial.sv
// m2ts_serial: emits the digits of one timestamp as ascii, one character per cycle
// depends on m2ts_pkg (digits_t, character and format codes)

module m2ts_serial (
  input  logic              clk,
  input  logic              rst,
  input  logic              fmt,
  input  logic              in_valid,
  output logic              in_ready,
  input  m2ts_pkg::digits_t in_digits,
  output logic              char_strobe,
  output logic [6:0]        char_out,
  output logic              last
);

  // character positions within the timestamp
  localparam logic [3:0] POS_H1      = 4'd0;
  localparam logic [3:0] POS_H0      = 4'd1;
  localparam logic [3:0] POS_COLON_A = 4'd2;
  localparam logic [3:0] POS_M1      = 4'd3;
  localparam logic [3:0] POS_M0      = 4'd4;
  localparam logic [3:0] POS_COLON_B = 4'd5;
  localparam logic [3:0] POS_S1      = 4'd6;
  localparam logic [3:0] POS_S0      = 4'd7;
  localparam logic [3:0] POS_SEP     = 4'd8;
  localparam logic [3:0] POS_F2      = 4'd9;
  localparam logic [3:0] POS_F1      = 4'd10;
  localparam logic [3:0] POS_F0      = 4'd11;

  logic              active;
  logic [3:0]        pos;
  m2ts_pkg::digits_t dig;
  logic              at_end;
  logic              load;
  logic [6:0]        cur_char;

  // the last position depends on the format
  assign at_end   = (fmt == m2ts_pkg::FMT_ASS) ? (pos == POS_F1) : (pos == POS_F0);
  assign in_ready = !active || at_end;
  assign load     = in_valid && in_ready;

  // character select
  always_comb begin
    case (pos)
      POS_H1:      cur_char = m2ts_pkg::CH_ZERO + 7'(dig.h1);
      POS_H0:      cur_char = m2ts_pkg::CH_ZERO + 7'(dig.h0);
      POS_COLON_A,
      POS_COLON_B: cur_char = m2ts_pkg::CH_COLON;
      POS_M1:      cur_char = m2ts_pkg::CH_ZERO + 7'(dig.m1);
      POS_M0:      cur_char = m2ts_pkg::CH_ZERO + 7'(dig.m0);
      POS_S1:      cur_char = m2ts_pkg::CH_ZERO + 7'(dig.s1);
      POS_S0:      cur_char = m2ts_pkg::CH_ZERO + 7'(dig.s0);
      POS_SEP:     cur_char = (fmt == m2ts_pkg::FMT_ASS) ? m2ts_pkg::CH_DOT
                                                         : m2ts_pkg::CH_COMMA;
      POS_F2:      cur_char = m2ts_pkg::CH_ZERO + 7'(dig.f2);
      POS_F1:      cur_char = m2ts_pkg::CH_ZERO + 7'(dig.f1);
      POS_F0:      cur_char = m2ts_pkg::CH_ZERO + 7'(dig.f0);
      default:     cur_char = m2ts_pkg::CH_ZERO;
    endcase
  end

  // position counter and output strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      pos         <= POS_H1;
      char_strobe <= 1'b0;
    end else begin
      char_strobe <= active;
      if (load) begin
        active <= 1'b1;
        pos    <= POS_H1;
      end else if (active && at_end) begin
        active <= 1'b0;
      end else if (active) begin
        pos <= pos + 4'd1;
      end
    end
  end

  // output character and captured digits
  always_ff @(posedge clk) begin
    char_out <= cur_char;
    last     <= at_end;
    if (load) dig <= in_digits;
  end

endmodule

>>> hw/rtl/millis_to_timestamp_text.sv
// millis_to_timestamp_text: top level, format register and pipeline hookup
// depends on m2ts_pkg, m2ts_divide, m2ts_digits, m2ts_serial

// A millisecond count is taken when start is high and busy is low. It is
// written out as HH:MM:SS,mmm (subtitle_format 0, twelve characters) or
// HH:MM:SS.cc (format 1, eleven characters, last ms digit dropped), one
// character per cycle on char_out with char_strobe high for that cycle and
// last high on the final character; hours wrap modulo 100. The receiver
// cannot stall. The character serializer sets the sustained rate: it takes a
// new count only while it sends the final character of the one before. A
// seven-stage division and digit pipeline ahead of it holds counts that are
// taken while earlier text is still going out; busy rises only when that
// pipeline is full.

module millis_to_timestamp_text (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] millis,
  output logic        char_strobe,
  output logic [6:0]  char_out,
  output logic        last
);

  logic              subtitle_format;
  logic              div_in_ready;
  logic              div_valid;
  logic              dig_in_ready;
  m2ts_pkg::hmsf_t   div_time;
  logic              dig_valid;
  logic              ser_in_ready;
  m2ts_pkg::digits_t dig_out;

  // format register
  always_ff @(posedge clk) begin
    if (rst) begin
      subtitle_format <= m2ts_pkg::FMT_SRT;
    end else if (cfg_we) begin
      subtitle_format <= cfg_wdata;
    end
  end

  assign busy = !div_in_ready;

  // time split
  m2ts_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .in_ready  (div_in_ready),
    .millis    (millis),
    .out_valid (div_valid),
    .out_ready (dig_in_ready),
    .out_time  (div_time)
  );

  // decimal digits
  m2ts_digits u_digits (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (div_valid),
    .in_ready   (dig_in_ready),
    .in_time    (div_time),
    .out_valid  (dig_valid),
    .out_ready  (ser_in_ready),
    .out_digits (dig_out)
  );

  // character output
  m2ts_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .fmt         (subtitle_format),
    .in_valid    (dig_valid),
    .in_ready    (ser_in_ready),
    .in_digits   (dig_out),
    .char_strobe (char_strobe),
    .char_out    (char_out),
    .last        (last)
  );

  // a timestamp goes out without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    char_strobe && !last |=> char_strobe)
    else $error("gap inside a timestamp transaction");

  // the final character is always a digit
  a_last_digit: assert property (@(posedge clk) disable iff (rst)
    char_strobe && last |-> (char_out >= m2ts_pkg::CH_ZERO) && (char_out <= 7'h39))
    else $error("final character is not a digit");

  // a separator is never the final character
  a_sep_not_last: assert property (@(posedge clk) disable iff (rst)
    char_strobe && (char_out == m2ts_pkg::CH_COLON || char_out == m2ts_pkg::CH_COMMA
                    || char_out == m2ts_pkg::CH_DOT) |-> !last)
    else $error("separator marked as last");

endmodule

>>> bench/millis_to_timestamp_text_test.sv
// millis_to_timestamp_text_test: self-checking bench for the millisecond to timestamp text block
// depends on m2ts_pkg and millis_to_timestamp_text; predicts every character and compares
`timescale 1ns / 100ps

module millis_to_timestamp_text_test;

  localparam int unsigned MS_PER_HOUR   = 3600000;
  localparam int unsigned MS_PER_MINUTE = 60000;
  localparam int unsigned MS_PER_SECOND = 1000;
  localparam int unsigned HOUR_WRAP     = 100;
  localparam int          SETTLE_CYCLES = 20;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          REPORT_LIMIT  = 10;
  localparam int          PHASE_ITEMS   = 56;

  // one expected character of the timestamp text
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } text_char_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        start;
  logic        busy;
  logic [31:0] millis;
  logic        char_strobe;
  logic [6:0]  char_out;
  logic        last;

  text_char_t expected_text_q[$];
  text_char_t next_char;
  logic       subtitle_fmt;
  logic       idle_gaps;
  int         mismatches;
  int         chars_checked;
  int         srt_stamps;
  int         ass_stamps;
  int         idle_cycles;

  millis_to_timestamp_text i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .start       (start),
    .busy        (busy),
    .millis      (millis),
    .char_strobe (char_strobe),
    .char_out    (char_out),
    .last        (last)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // queue one predicted character
  function automatic void queue_char(input logic [6:0] ch, input logic is_last);
    text_char_t c;
    c.ch = ch;
    c.last = is_last;
    expected_text_q.push_back(c);
  endfunction

  // expected text for one count: HH:MM:SS,mmm or HH:MM:SS.cc, hours modulo 100
  function automatic void predict_timestamp_text(input logic [31:0] ms, input logic fmt);
    int unsigned t;
    int unsigned hh;
    int unsigned mm;
    int unsigned ss;
    int unsigned ff;
    t  = ms;
    hh = (t / MS_PER_HOUR) % HOUR_WRAP;
    mm = (t % MS_PER_HOUR) / MS_PER_MINUTE;
    ss = (t % MS_PER_MINUTE) / MS_PER_SECOND;
    ff = t % MS_PER_SECOND;
    queue_char(m2ts_pkg::CH_ZERO + 7'(hh / 10), 1'b0);
    queue_char(m2ts_pkg::CH_ZERO + 7'(hh % 10), 1'b0);
    queue_char(m2ts_pkg::CH_COLON, 1'b0);
    queue_char(m2ts_pkg::CH_ZERO + 7'(mm / 10), 1'b0);
    queue_char(m2ts_pkg::CH_ZERO + 7'(mm % 10), 1'b0);
    queue_char(m2ts_pkg::CH_COLON, 1'b0);
    queue_char(m2ts_pkg::CH_ZERO + 7'(ss / 10), 1'b0);
    queue_char(m2ts_pkg::CH_ZERO + 7'(ss % 10), 1'b0);
    if (fmt == m2ts_pkg::FMT_ASS) begin
      // centiseconds, last ms digit truncated
      queue_char(m2ts_pkg::CH_DOT, 1'b0);
      queue_char(m2ts_pkg::CH_ZERO + 7'(ff / 100), 1'b0);
      queue_char(m2ts_pkg::CH_ZERO + 7'((ff / 10) % 10), 1'b1);
    end else begin
      queue_char(m2ts_pkg::CH_COMMA, 1'b0);
      queue_char(m2ts_pkg::CH_ZERO + 7'(ff / 100), 1'b0);
      queue_char(m2ts_pkg::CH_ZERO + 7'((ff / 10) % 10), 1'b0);
      queue_char(m2ts_pkg::CH_ZERO + 7'(ff % 10), 1'b1);
    end
  endfunction

  // random count: full range, under 100 hours, near unit boundaries, small, near the 100 hour wrap
  function automatic logic [31:0] random_millis();
    longint unsigned unit;
    longint unsigned base;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 359999999);
      2: begin
        case ($urandom_range(0, 3))
          0: unit = MS_PER_SECOND;
          1: unit = MS_PER_MINUTE;
          2: unit = MS_PER_HOUR;
          default: unit = MS_PER_HOUR * HOUR_WRAP;
        endcase
        base = unit * $urandom_range(1, 32'(64'hFFFF_FFFF / unit));
        return 32'(base + $urandom_range(0, 2) - 1);
      end
      3: return $urandom_range(0, 99999);
      default: return $urandom_range(359990000, 360010000);
    endcase
  endfunction

  // one transaction on the command port; entered and left just after a falling edge
  task automatic send_millis(input logic [31:0] value);
    // idle cycles picked one at a time
    while (idle_gaps && $urandom_range(0, 99) < 23) begin
      start <= 1'b0;
      millis <= $urandom;
      @(negedge clk);
    end
    start <= 1'b1;
    millis <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_timestamp_text(value, subtitle_fmt);
    if (subtitle_fmt == m2ts_pkg::FMT_ASS) ass_stamps++;
    else srt_stamps++;
    @(negedge clk);
  endtask

  // let the text drain, then write the format register while idle
  task automatic set_subtitle_format(input logic fmt);
    start <= 1'b0;
    while (expected_text_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= fmt;
    @(negedge clk);
    cfg_we <= 1'b0;
    subtitle_fmt = fmt;
  endtask

  // srt text straight out of reset: field extremes and hour wrap
  task automatic test_srt_directed();
    send_millis(32'd0);
    send_millis(32'd999);
    send_millis(32'd1000);
    send_millis(32'd59999);
    send_millis(32'd3599999);
    send_millis(32'd3600000);
    send_millis(32'd359999999);   // 99:59:59,999
    send_millis(32'd360000000);   // hours wrap to 00
    send_millis(32'd12345678);
    send_millis(32'hFFFF_FFFF);
    send_millis(32'hAAAA_AAAA);
    send_millis(32'h5555_5555);
  endtask

  // ass text: dot separator and truncated centiseconds, then back to srt
  task automatic test_ass_directed();
    set_subtitle_format(m2ts_pkg::FMT_ASS);
    send_millis(32'd0);
    send_millis(32'd999);         // .99, not rounded
    send_millis(32'd995);
    send_millis(32'd9);
    send_millis(32'd359999999);
    send_millis(32'd360000001);
    send_millis(32'hFFFF_FFFF);
    set_subtitle_format(m2ts_pkg::FMT_SRT);
    send_millis(32'd86399999);
    send_millis(32'd1);
  endtask

  // random counts in phases, first ass then srt then random formats, one phase without gaps
  task automatic test_random_phases();
    logic fmt;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase < 2) fmt = (phase == 0) ? m2ts_pkg::FMT_ASS : m2ts_pkg::FMT_SRT;
      else fmt = logic'($urandom_range(0, 1));
      set_subtitle_format(fmt);
      idle_gaps = (phase != 1);
      for (int n = 0; n < PHASE_ITEMS; n++) send_millis(random_millis());
    end
  endtask

  // compare each character with the oldest prediction, track activity
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((start && !busy) || char_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (char_strobe) begin
        if (expected_text_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected character %h last %b", char_out, last);
        end else begin
          next_char = expected_text_q.pop_front();
          chars_checked++;
          if (char_out !== next_char.ch || last !== next_char.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("char mismatch: expected %h last %b, got %h last %b",
                       next_char.ch, next_char.last, char_out, last);
          end
        end
      end
    end
  end

  // watchdog: no transaction for too long ends the run
  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    start = 1'b0;
    millis = '0;
    subtitle_fmt = m2ts_pkg::FMT_SRT;
    idle_gaps = 1'b1;
    mismatches = 0;
    chars_checked = 0;
    srt_stamps = 0;
    ass_stamps = 0;
    idle_cycles = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_srt_directed();
    test_ass_directed();
    test_random_phases();

    // drain and look for stray characters
    start <= 1'b0;
    while (expected_text_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("timestamps sent: %0d srt, %0d ass; characters checked: %0d",
             srt_stamps, ass_stamps, chars_checked);
    $display("mismatches: %0d, predictions left over: %0d",
             mismatches, expected_text_q.size());
    if (mismatches == 0 && expected_text_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
